// File: rtl/fir_filter_50_tap_unit_defines.svh
// assertion macros used by the checker
`ifndef FIR_FILTER_50_TAP_UNIT_DEFINES_SVH
`define FIR_FILTER_50_TAP_UNIT_DEFINES_SVH

// same-cycle implication
`define FIR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/fir50_pkg.sv
`default_nettype none

package fir50_pkg;

  localparam int OUT_BITS     = 37;
  localparam int TAP_IDX_BITS = 6;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/fir50_cell.sv
`default_nettype none

module fir50_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fir50_pkg::cell_ctl_t          ctl,
  input  wire logic                          load_en,
  input  wire logic signed [COEF_BITS-1:0]   load_val,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
  input  wire logic signed [COEF_BITS-1:0]   right_coef,
  output logic signed [SAMPLE_BITS-1:0]      sample,
  output logic signed [COEF_BITS-1:0]        coef
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
      coef   <= '0;
    end else if (ctl.rotate) begin
      sample <= right_sample;
      coef   <= right_coef;
    end else begin
      if (ctl.shift) begin
        sample <= left_sample;
      end
      if (load_en) begin
        coef <= load_val;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/fir50_mac.sv
`default_nettype none

module fir50_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              clr,
  input  wire logic                              mul_en,
  input  wire logic signed [SAMPLE_BITS-1:0]     a,
  input  wire logic signed [COEF_BITS-1:0]       b,
  output logic signed [fir50_pkg::OUT_BITS-1:0]  acc
);

  localparam int PW = SAMPLE_BITS + COEF_BITS;
  localparam int EW = PW + fir50_pkg::OUT_BITS;

  logic signed [PW-1:0] prod;
  logic                 prod_vld;
  logic signed [EW-1:0] prod_ext;

  assign prod_ext = EW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= a * b;
    end
    if (clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod_ext[fir50_pkg::OUT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/fir_filter_50_tap_unit.sv
`default_nettype none

// Direct-form FIR filter, TAPS taps, with a coefficient table loaded one tap per beat.
// A beat with action 0 shifts sample_in into the delay line and then offers the
// full-precision Q.30 sum on filtered_out (37 bits, wrapping if wider); no new beat is
// taken until that sum is handed to the output register. A beat with action 1 writes
// tap tap_index and gives no result; an index of TAPS or more is dropped. The single
// multiply-accumulate unit sets the pace: the row of tap cells rotates past it one tap
// per cycle, then come the product register, a flush state and the hand-off to the output
// register, which lets the next beat in while the result waits. Reset clears both tables.
module fir_filter_50_tap_unit #(
  parameter int TAPS        = 50,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   action,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_in,
  input  wire logic [fir50_pkg::TAP_IDX_BITS-1:0]     tap_index,
  input  wire logic signed [COEF_BITS-1:0]            tap_value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [fir50_pkg::OUT_BITS-1:0]       filtered_out
);

  localparam int CW = (TAPS > 1) ? $clog2(TAPS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  logic accept;
  logic take_sample;
  logic take_coef;
  logic emit;

  fir50_pkg::cell_ctl_t ctl;

  logic signed [SAMPLE_BITS-1:0] samp [TAPS];
  logic signed [COEF_BITS-1:0]   coef [TAPS];

  logic signed [fir50_pkg::OUT_BITS-1:0] acc;

  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign take_sample = accept && (action == fir50_pkg::ACT_SAMPLE);
  assign take_coef   = accept && (action == fir50_pkg::ACT_COEF);
  assign emit        = (state == ST_DONE) && (!out_valid || out_ready);

  assign ctl.shift  = take_sample;
  assign ctl.rotate = (state == ST_RUN);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (take_sample) begin
          state_next = ST_RUN;
          cnt_next   = '0;
        end
      end
      ST_RUN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(TAPS - 1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      filtered_out <= acc;
    end
  end

  // tap row: shifts right on a new sample, rotates left past the mac
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_s;
    logic signed [SAMPLE_BITS-1:0] right_s;
    logic signed [COEF_BITS-1:0]   right_c;
    logic                          ld;

    if (k == 0) begin : g_first
      assign left_s = sample_in;
    end else begin : g_mid
      assign left_s = samp[k-1];
    end

    if (k == TAPS - 1) begin : g_last
      assign right_s = samp[0];
      assign right_c = coef[0];
    end else begin : g_body
      assign right_s = samp[k+1];
      assign right_c = coef[k+1];
    end

    assign ld = take_coef && (int'(tap_index) == k);

    fir50_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF_BITS  (COEF_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .load_en     (ld),
      .load_val    (tap_value),
      .left_sample (left_s),
      .right_sample(right_s),
      .right_coef  (right_c),
      .sample      (samp[k]),
      .coef        (coef[k])
    );
  end

  fir50_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .clr   (take_sample),
    .mul_en(state == ST_RUN),
    .a     (samp[0]),
    .b     (coef[0]),
    .acc   (acc)
  );

endmodule

`default_nettype wire

// File: rtl/fir50_checker.sv
`default_nettype none

`include "fir_filter_50_tap_unit_defines.svh"

module fir50_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                action,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [fir50_pkg::OUT_BITS-1:0] filtered_out
);

  logic take_sample;
  logic take_coef;

  assign take_sample = in_valid && in_ready && (action == fir50_pkg::ACT_SAMPLE);
  assign take_coef   = in_valid && in_ready && (action == fir50_pkg::ACT_COEF);

  // stalled result holds
  `FIR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(filtered_out))

  // a sample beat closes the input until its sum is out
  `FIR_ASSERT_NEXT(a_busy_after_sample, clk, rst, take_sample, !in_ready)

  // a coefficient beat yields no result
  `FIR_ASSERT_NEXT(a_coef_silent, clk, rst, take_coef && !out_valid, !out_valid)

  // a new result only appears after a busy cycle
  `FIR_ASSERT_NOW(a_result_after_busy, clk, rst, $rose(out_valid), !$past(in_ready))

endmodule

bind fir_filter_50_tap_unit fir50_checker u_fir50_checker (.*);

`default_nettype wire
